// ===== rtl/core/lzwvd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwvd_pkg: shared types and constants of the LZW decoder
// Holds the request and response layouts, the status codes, the stream phase
// and sequencer state encodings, and the fixed code and table sizes.
// ----------------------------------------------------------------------------
package lzwvd_pkg;

	localparam int MAX_CODE_BITS = 13;
	localparam int MIN_CODE_BITS = 9;
	localparam int TABLE_ENTRIES = 8192;
	localparam int ADDR_W        = 13;
	localparam int CNT_W         = 14;
	localparam int CACHE_W       = 20;
	localparam int HELD_W        = 5;
	localparam int CW_W          = 4;

	localparam logic [CNT_W-1:0] CODE_CLEAR = 14'd256;
	localparam logic [CNT_W-1:0] CODE_END   = 14'd257;
	localparam logic [CNT_W-1:0] CODE_FIRST = 14'd258;
	localparam logic [CNT_W-1:0] NONE_MARK  = 14'h3FFF;

	typedef enum logic [1:0] {
		KIND_FEED   = 2'd0,
		KIND_PULL   = 2'd1,
		KIND_FINISH = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_ACCEPT = 3'd0,
		STAT_REFUSE = 3'd1,
		STAT_BYTE   = 3'd2,
		STAT_EMPTY  = 3'd3,
		STAT_OK     = 3'd4,
		STAT_FAIL   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_LITERAL = 3'd1,
		PH_DATA    = 3'd2,
		PH_ENDED   = 3'd3,
		PH_FAILED  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE     = 3'd0,
		S_EXTRACT  = 3'd1,
		S_WALK_RD  = 3'd2,
		S_WALK_DAT = 3'd3,
		S_ROOT     = 3'd4,
		S_COMMIT   = 3'd5,
		S_PULL     = 3'd6
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
	} rsp_t;

endpackage

// ===== rtl/core/lzw_variable_width_decoder.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder: LSB-first LZW decoder, 9 to 13 bit codes
// Refusals, empty pulls, finishes and requests in the failed state have
// their response registered on acceptance; a byte pull first reads the stack
// in S_PULL. A feed passes S_EXTRACT once per code checked; each data code
// walks the single-port prefix and suffix RAMs in S_WALK_RD and S_WALK_DAT
// per table entry, then passes S_ROOT and S_COMMIT. One item at a time.
// Reset clears all control state; the tables and stack are not cleared.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lzwvd_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lzwvd_pkg::rsp_t rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [31:0]     cfg_data
);

	import lzwvd_pkg::*;

	// Sequencer and stream state.
	state_t               state_q, state_d;
	phase_t               phase_q, phase_d;
	logic [CACHE_W-1:0]   cache_q, cache_d;
	logic [HELD_W-1:0]    held_q, held_d;
	logic [CW_W-1:0]      cw_q, cw_d;
	logic [CNT_W-1:0]     nfc_q, nfc_d;
	logic [CNT_W-1:0]     prev_q, prev_d;
	logic [CNT_W-1:0]     stack_cnt_q, stack_cnt_d;
	logic [31:0]          produced_q, produced_d;
	logic [31:0]          exp_len_q;

	// Per-code working registers of the table walk.
	logic [CNT_W-1:0]     code_q, code_d;
	logic [CNT_W-1:0]     walk_q, walk_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 kwk_q, kwk_d;
	logic [7:0]           root_q, root_d;

	// Response register.
	logic                 rsp_valid_q, rsp_valid_d;
	rsp_t                 rsp_q, rsp_d;

	// RAM ports.
	logic                 stk_we, tab_we;
	logic [ADDR_W-1:0]    stk_addr, tab_addr;
	logic [7:0]           stk_wdata, stk_rdata, suf_rdata;
	logic [ADDR_W-1:0]    pre_rdata;

	// Code extraction helpers.
	logic [CNT_W-1:0]     cur_code;
	logic [CNT_W-1:0]     code_mask;
	logic [CNT_W:0]       cw_limit;
	logic [CNT_W-1:0]     nfc_inc;
	logic [32:0]          room_sum;
	logic                 req_acc;

	lzwvd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.addr  (stk_addr),
		.wdata (stk_wdata),
		.rdata (stk_rdata)
	);

	lzwvd_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
		.clk   (clk),
		.we    (tab_we),
		.addr  (tab_addr),
		.wdata (prev_q[ADDR_W-1:0]),
		.rdata (pre_rdata)
	);

	lzwvd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
		.clk   (clk),
		.we    (tab_we),
		.addr  (tab_addr),
		.wdata (root_q),
		.rdata (suf_rdata)
	);

	// The block takes a request only when idle and when no response waits.
	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// The low code_width bits of the cache form the next code.
	assign code_mask = CNT_W'((15'd1 << cw_q) - 15'd1);
	assign cur_code  = CNT_W'(cache_q) & code_mask;
	assign cw_limit  = (CNT_W+1)'(1) << cw_q;
	assign nfc_inc   = nfc_q + CNT_W'(1);
	assign room_sum  = {1'b0, produced_q} + {19'b0, cnt_q};

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cache_d     = cache_q;
		held_d      = held_q;
		cw_d        = cw_q;
		nfc_d       = nfc_q;
		prev_d      = prev_q;
		stack_cnt_d = stack_cnt_q;
		produced_d  = produced_q;
		code_d      = code_q;
		walk_d      = walk_q;
		cnt_d       = cnt_q;
		kwk_d       = kwk_q;
		root_d      = root_q;
		rsp_valid_d = rsp_valid_q;
		rsp_d       = rsp_q;
		stk_we      = 1'b0;
		stk_addr    = cnt_q[ADDR_W-1:0];
		stk_wdata   = 8'd0;
		tab_we      = 1'b0;
		tab_addr    = walk_q[ADDR_W-1:0];

		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					rsp_d.out_byte = 8'd0;
					if (phase_q == PH_FAILED) begin
						rsp_d.status = STAT_FAIL;
						rsp_valid_d  = 1'b1;
					end else begin
						case (req.kind)
							KIND_FEED: begin
								if (stack_cnt_q != '0) begin
									rsp_d.status = STAT_REFUSE;
									rsp_valid_d  = 1'b1;
								end else if (phase_q == PH_ENDED) begin
									phase_d      = PH_FAILED;
									rsp_d.status = STAT_FAIL;
									rsp_valid_d  = 1'b1;
								end else begin
									cache_d = cache_q |
										(CACHE_W'({12'd0, req.in_byte}) << held_q);
									held_d  = held_q + HELD_W'(8);
									state_d = S_EXTRACT;
								end
							end
							KIND_PULL: begin
								if (stack_cnt_q == '0) begin
									rsp_d.status = STAT_EMPTY;
									rsp_valid_d  = 1'b1;
								end else begin
									stack_cnt_d = stack_cnt_q - CNT_W'(1);
									stk_addr    = stack_cnt_d[ADDR_W-1:0];
									state_d     = S_PULL;
								end
							end
							KIND_FINISH: begin
								if (stack_cnt_q != '0) begin
									rsp_d.status = STAT_REFUSE;
								end else if (phase_q == PH_ENDED && cache_q == '0 &&
										produced_q == exp_len_q) begin
									rsp_d.status = STAT_OK;
								end else begin
									phase_d      = PH_FAILED;
									rsp_d.status = STAT_FAIL;
								end
								rsp_valid_d = 1'b1;
							end
							default: begin
								rsp_d.status = STAT_REFUSE;
								rsp_valid_d  = 1'b1;
							end
						endcase
					end
				end
			end
			S_PULL: begin
				rsp_d.out_byte = stk_rdata;
				rsp_d.status   = STAT_BYTE;
				rsp_valid_d    = 1'b1;
				state_d        = S_IDLE;
			end
			S_EXTRACT: begin
				if (held_q >= HELD_W'(cw_q) && stack_cnt_q == '0 &&
						phase_q != PH_ENDED) begin
					cache_d = cache_q >> cw_q;
					held_d  = held_q - HELD_W'(cw_q);
					code_d  = cur_code;
					case (phase_q)
						PH_START: begin
							if (cur_code != CODE_CLEAR) begin
								phase_d = PH_FAILED;
							end else begin
								cw_d    = CW_W'(MIN_CODE_BITS);
								nfc_d   = CODE_FIRST;
								prev_d  = NONE_MARK;
								phase_d = PH_LITERAL;
							end
						end
						PH_LITERAL: begin
							if (cur_code == CODE_END) begin
								phase_d = PH_ENDED;
							end else if (cur_code >= CODE_CLEAR ||
									produced_q >= exp_len_q) begin
								phase_d = PH_FAILED;
							end else begin
								stk_we      = 1'b1;
								stk_addr    = '0;
								stk_wdata   = cur_code[7:0];
								stack_cnt_d = CNT_W'(1);
								produced_d  = produced_q + 32'd1;
								prev_d      = cur_code;
								phase_d     = PH_DATA;
							end
						end
						default: begin
							if (cur_code == CODE_END) begin
								phase_d = PH_ENDED;
							end else if (cur_code == CODE_CLEAR) begin
								cw_d    = CW_W'(MIN_CODE_BITS);
								nfc_d   = CODE_FIRST;
								prev_d  = NONE_MARK;
								phase_d = PH_LITERAL;
							end else if (nfc_q >= CNT_W'(TABLE_ENTRIES) ||
									cur_code > nfc_q) begin
								phase_d = PH_FAILED;
							end else begin
								kwk_d   = (cur_code == nfc_q);
								walk_d  = (cur_code == nfc_q) ? prev_q : cur_code;
								cnt_d   = (cur_code == nfc_q) ? CNT_W'(1) : '0;
								state_d = S_WALK_RD;
							end
						end
					endcase
					if (phase_d == PH_FAILED) begin
						stack_cnt_d  = '0;
						rsp_d        = '{out_byte: 8'd0, status: STAT_FAIL};
						rsp_valid_d  = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					rsp_d       = '{out_byte: 8'd0, status: STAT_ACCEPT};
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_WALK_RD: begin
				if (walk_q >= CODE_FIRST) begin
					if (walk_q >= nfc_q || cnt_q >= CNT_W'(TABLE_ENTRIES)) begin
						phase_d     = PH_FAILED;
						stack_cnt_d = '0;
						rsp_d       = '{out_byte: 8'd0, status: STAT_FAIL};
						rsp_valid_d = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_WALK_DAT;
					end
				end else begin
					state_d = S_ROOT;
				end
			end
			S_WALK_DAT: begin
				stk_we    = 1'b1;
				stk_wdata = suf_rdata;
				cnt_d     = cnt_q + CNT_W'(1);
				walk_d    = {1'b0, pre_rdata};
				state_d   = S_WALK_RD;
			end
			S_ROOT: begin
				if (walk_q >= CODE_CLEAR || cnt_q >= CNT_W'(TABLE_ENTRIES)) begin
					phase_d     = PH_FAILED;
					stack_cnt_d = '0;
					rsp_d       = '{out_byte: 8'd0, status: STAT_FAIL};
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end else begin
					root_d    = walk_q[7:0];
					stk_we    = 1'b1;
					stk_wdata = walk_q[7:0];
					cnt_d     = cnt_q + CNT_W'(1);
					state_d   = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (room_sum > {1'b0, exp_len_q}) begin
					phase_d     = PH_FAILED;
					stack_cnt_d = '0;
					rsp_d       = '{out_byte: 8'd0, status: STAT_FAIL};
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end else begin
					// In the KwKwK case the last byte equals the first.
					stk_we      = kwk_q;
					stk_addr    = '0;
					stk_wdata   = root_q;
					tab_we      = 1'b1;
					tab_addr    = nfc_q[ADDR_W-1:0];
					stack_cnt_d = cnt_q;
					produced_d  = room_sum[31:0];
					nfc_d       = nfc_inc;
					if ({1'b0, nfc_inc} >= cw_limit && cw_q < CW_W'(MAX_CODE_BITS)) begin
						cw_d = cw_q + CW_W'(1);
					end
					prev_d  = code_q;
					state_d = S_EXTRACT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_START;
			cache_q     <= '0;
			held_q      <= '0;
			cw_q        <= CW_W'(MIN_CODE_BITS);
			nfc_q       <= CODE_FIRST;
			prev_q      <= NONE_MARK;
			stack_cnt_q <= '0;
			produced_q  <= '0;
			exp_len_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			cache_q     <= cache_d;
			held_q      <= held_d;
			cw_q        <= cw_d;
			nfc_q       <= nfc_d;
			prev_q      <= prev_d;
			stack_cnt_q <= stack_cnt_d;
			produced_q  <= produced_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_valid && cfg_ready) begin
				exp_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
		walk_q <= walk_d;
		cnt_q  <= cnt_d;
		kwk_q  <= kwk_d;
		root_q <= root_d;
		rsp_q  <= rsp_d;
	end

	// A failed stream never keeps bytes on the stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAILED |-> stack_cnt_q == '0)
		else $error("failed stream holds stacked bytes");

	// The code width stays within its legal range.
	assert property (@(posedge clk) disable iff (!arst_n)
		cw_q >= CW_W'(MIN_CODE_BITS) && cw_q <= CW_W'(MAX_CODE_BITS))
		else $error("code width out of range");

	// The sequencer only leaves idle because a request was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !req_acc |=> state_q == S_IDLE)
		else $error("sequencer started without a request");

	// The bit cache never holds more bits than it is wide.
	assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(CACHE_W))
		else $error("bit cache overflow");

endmodule

// ===== rtl/core/lzwvd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwvd_ram: single-port synchronous RAM
// One access per cycle at a single address; a write also reads the old data there. Read data is registered.
// ----------------------------------------------------------------------------
module lzwvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== tb/lzw_variable_width_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_test: self-checking bench for the LZW decoder
// Builds LSB-first LZW streams with an on-the-fly encoder, feeds them byte by
// byte with pulls in between, predicts every response with a cycle-free model
// of the decoder and checks each response in order. The request side idles and
// the response side stalls at random. Each run closes with one randomly chosen failing ending.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_test;
	import lzwvd_pkg::*;

	// The decode tracker mirrors the decoder state. It predicts the response
	// of every accepted request and compares arriving responses in order.
	class decode_tracker;
		bit [12:0]   prefix_mem[TABLE_ENTRIES];
		bit [7:0]    suffix_mem[TABLE_ENTRIES];
		bit [7:0]    byte_stack[TABLE_ENTRIES];
		int unsigned stack_depth, cache, held, width, avail_code, last_code;
		int unsigned produced, length_goal;
		phase_t      ph;
		rsp_t        pending_rsp[$];
		int          mismatches;

		function new();
			stack_depth = 0;
			cache = 0;
			held = 0;
			width = MIN_CODE_BITS;
			avail_code = CODE_FIRST;
			last_code = NONE_MARK;
			ph = PH_START;
			produced = 0;
			length_goal = 0;
			mismatches = 0;
		endfunction

		function bit room(int unsigned n);
			return (64'(produced) + 64'(n)) <= 64'(length_goal);
		endfunction

		function void restart_table();
			width = MIN_CODE_BITS;
			avail_code = CODE_FIRST;
			last_code = NONE_MARK;
			ph = PH_LITERAL;
		endfunction

		function void go_failed();
			ph = PH_FAILED;
			stack_depth = 0;
		endfunction

		// Expand one data code onto the stack and add the new table entry.
		function bit expand_code(int unsigned code);
			int unsigned walk, cnt;
			bit          kwk;
			bit [7:0]    root;
			if (avail_code >= TABLE_ENTRIES || code > avail_code)
				return 0;
			// A code equal to the next free one is the string-char-string case:
			// its last byte equals the first byte of the previous string.
			kwk = (code == avail_code);
			walk = kwk ? last_code : code;
			cnt = kwk ? 1 : 0;
			while (walk >= CODE_FIRST) begin
				if (walk >= avail_code || cnt >= TABLE_ENTRIES)
					return 0;
				byte_stack[cnt] = suffix_mem[walk];
				cnt++;
				walk = prefix_mem[walk];
			end
			if (walk >= CODE_CLEAR || cnt >= TABLE_ENTRIES)
				return 0;
			root = walk[7:0];
			byte_stack[cnt] = root;
			cnt++;
			if (kwk)
				byte_stack[0] = root;
			if (!room(cnt))
				return 0;
			stack_depth = cnt;
			produced += cnt;
			prefix_mem[avail_code] = last_code[12:0];
			suffix_mem[avail_code] = root;
			avail_code++;
			if (avail_code >= (1 << width) && width < MAX_CODE_BITS)
				width++;
			last_code = code;
			return 1;
		endfunction

		function bit take_code(int unsigned code);
			if (ph == PH_START) begin
				if (code != CODE_CLEAR)
					return 0;
				restart_table();
				return 1;
			end
			if (ph == PH_LITERAL) begin
				if (code == CODE_END) begin
					ph = PH_ENDED;
					return 1;
				end
				if (code >= CODE_CLEAR || !room(1))
					return 0;
				byte_stack[0] = code[7:0];
				stack_depth = 1;
				produced++;
				last_code = code;
				ph = PH_DATA;
				return 1;
			end
			if (code == CODE_END) begin
				ph = PH_ENDED;
				return 1;
			end
			if (code == CODE_CLEAR) begin
				restart_table();
				return 1;
			end
			return expand_code(code);
		endfunction

		function status_t note_request(req_t r);
			status_t     st;
			bit [7:0]    ob;
			int unsigned code;
			ob = 8'h00;
			if (ph == PH_FAILED) begin
				st = STAT_FAIL;
			end else begin
				case (r.kind)
					KIND_FEED: begin
						if (stack_depth != 0) begin
							st = STAT_REFUSE;
						end else if (ph == PH_ENDED) begin
							go_failed();
							st = STAT_FAIL;
						end else begin
							cache |= int'(r.in_byte) << held;
							held += 8;
							st = STAT_ACCEPT;
							while (held >= width && stack_depth == 0 && ph != PH_ENDED) begin
								code = cache & ((1 << width) - 1);
								cache >>= width;
								held -= width;
								if (!take_code(code)) begin
									go_failed();
									st = STAT_FAIL;
									break;
								end
							end
						end
					end
					KIND_PULL: begin
						if (stack_depth == 0) begin
							st = STAT_EMPTY;
						end else begin
							stack_depth--;
							ob = byte_stack[stack_depth];
							st = STAT_BYTE;
						end
					end
					KIND_FINISH: begin
						if (stack_depth != 0) begin
							st = STAT_REFUSE;
						end else if (ph == PH_ENDED && cache == 0 && produced == length_goal) begin
							st = STAT_OK;
						end else begin
							go_failed();
							st = STAT_FAIL;
						end
					end
					default: st = STAT_REFUSE;
				endcase
			end
			pending_rsp.push_back('{out_byte: ob, status: st});
			return st;
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: response with none expected: byte %h status %0d",
						$realtime, got.out_byte, got.status);
				mismatches++;
				return;
			end
			want = pending_rsp.pop_front();
			if (want.out_byte !== got.out_byte || want.status !== got.status) begin
				if (mismatches < 10)
					$display("%0t: expected byte %h status %0d, got byte %h status %0d",
						$realtime, want.out_byte, want.status, got.out_byte, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	decode_tracker tracker;
	int            items_sent;
	int            hold_request;

	// Encoder side: code packer plus a copy of the decoder's width schedule.
	longint unsigned pack_bits;
	int              pack_count;
	int              enc_width;
	int              enc_next;
	bit              enc_literal;
	byte unsigned    stream_q[$];
	byte unsigned    plain_q[$];
	int              phrase_map[int];

	lzw_variable_width_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A generous ceiling, far above the longest run.
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Response side. Stalls come in runs, mostly short with an occasional long
	// one, and the stimulus can ask for one very long hold-off to back the
	// decoder up against its request port.
	int hold_left = 0;
	int run_left = 0;
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
		if (hold_request != 0) begin
			hold_request = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp_stall <= 1'b1;
			run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
		end else begin
			rsp_stall <= 1'b0;
			run_left = $urandom_range(0, 30);
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Append one code at the width the decoder will read it with, then
	// advance that width the way the decoder does after each entry.
	function void emit_code(int code);
		pack_bits |= longint'(code) << pack_count;
		pack_count += enc_width;
		while (pack_count >= 8) begin
			stream_q.push_back(pack_bits[7:0]);
			pack_bits >>= 8;
			pack_count -= 8;
		end
		if (code == CODE_CLEAR) begin
			enc_width = MIN_CODE_BITS;
			enc_next = CODE_FIRST;
			enc_literal = 1'b1;
		end else if (code != CODE_END) begin
			if (enc_literal) begin
				enc_literal = 1'b0;
			end else if (enc_next < TABLE_ENTRIES) begin
				enc_next++;
				if (enc_next >= (1 << enc_width) && enc_width < MAX_CODE_BITS)
					enc_width++;
			end
		end
	endfunction

	function void flush_bits();
		if (pack_count > 0)
			stream_q.push_back(pack_bits[7:0]);
		pack_bits = 0;
		pack_count = 0;
	endfunction

	function void fill_plain(int len, int alpha);
		plain_q.delete();
		repeat (len)
			plain_q.push_back(8'($urandom_range(0, alpha - 1)));
	endfunction

	// Compress plain_q as one cleared segment.
	function void encode_segment();
		int phrase, key, seg_next;
		phrase_map.delete();
		seg_next = CODE_FIRST;
		emit_code(CODE_CLEAR);
		phrase = plain_q[0];
		for (int i = 1; i < plain_q.size(); i++) begin
			key = (phrase << 8) | plain_q[i];
			if (phrase_map.exists(key)) begin
				phrase = phrase_map[key];
			end else begin
				emit_code(phrase);
				if (seg_next < TABLE_ENTRIES) begin
					phrase_map[key] = seg_next;
					seg_next++;
				end
				phrase = plain_q[i];
			end
		end
		emit_code(phrase);
	endfunction

	// One request; the valid stays high into the next request when no gap
	// is drawn.
	task automatic send(input kind_t k, input bit [7:0] b, output status_t st);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{kind: k, in_byte: b};
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		st = tracker.note_request(req);
		items_sent++;
	endtask

	task automatic drain_stack();
		status_t st;
		while (tracker.stack_depth > 0 && tracker.ph != PH_FAILED) begin
			if ($urandom_range(0, 19) == 0)
				send(KIND_NONE, 8'($urandom), st);
			send(KIND_PULL, 8'($urandom), st);
		end
	endtask

	// Feed the packed stream. Now and then a feed is sent while bytes are
	// still stacked, so the refusal path gets exercised and retried.
	task automatic feed_stream();
		status_t st;
		int      i;
		i = 0;
		while (i < stream_q.size() && tracker.ph != PH_FAILED) begin
			if ($urandom_range(0, 31) == 0)
				send(KIND_PULL, 8'($urandom), st);
			send(KIND_FEED, stream_q[i], st);
			if (st != STAT_REFUSE)
				i++;
			if (st == STAT_REFUSE || $urandom_range(0, 7) != 0)
				drain_stack();
		end
		stream_q.delete();
	endtask

	// The request side goes quiet so that no request is offered twice.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (tracker.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The length register is written only once every response is home.
	task automatic write_length(input bit [31:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.length_goal = v;
	endtask

	status_t st;
	int      seg_len;
	int      alpha;
	bit      hold_done;

	initial begin
		tracker = new();
		items_sent = 0;
		hold_request = 0;
		hold_done = 1'b0;
		pack_bits = 0;
		pack_count = 0;
		enc_width = MIN_CODE_BITS;
		enc_next = CODE_FIRST;
		enc_literal = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero length, an empty pull and the unused kind before
		// the stream starts, then extreme literals and a repeated byte run
		// that forces the string-char-string code.
		write_length(32'h0000_0000);
		send(KIND_PULL, 8'h00, st);
		send(KIND_NONE, 8'hFF, st);
		write_length(32'hFFFF_FFFF);
		plain_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
		repeat (12) plain_q.push_back(8'h61);
		encode_segment();
		feed_stream();

		// Random segments of random length over alphabets of varied size; a
		// narrow alphabet builds long chains and wide codes early.
		while (items_sent < 1750) begin
			seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
				: $urandom_range(1, 60);
			case ($urandom_range(0, 3))
				0: alpha = 1;
				1: alpha = 2;
				2: alpha = 8;
				default: alpha = 256;
			endcase
			fill_plain(seg_len, alpha);
			encode_segment();
			feed_stream();
			if (items_sent > 600 && !hold_done) begin
				hold_request = 1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 4) == 0)
				write_length(32'hFFFF_0000 | $urandom_range(0, 16'hFFFF));
			else if ($urandom_range(0, 5) == 0)
				wait_idle();
		end

		// One ending per run; each leaves the decoder in its sticky failure.
		case ($urandom_range(0, 5))
			0: begin
				// Clean end, two good finishes, then a feed past the end.
				if ($urandom_range(0, 1) == 0)
					emit_code(CODE_CLEAR);
				emit_code(CODE_END);
				flush_bits();
				feed_stream();
				write_length(tracker.produced);
				send(KIND_FINISH, 8'($urandom), st);
				send(KIND_FINISH, 8'($urandom), st);
				send(KIND_FEED, 8'($urandom), st);
			end
			1: begin
				// Length mismatch at finish.
				emit_code(CODE_END);
				flush_bits();
				feed_stream();
				write_length(tracker.produced + 1);
				send(KIND_FINISH, 8'($urandom), st);
			end
			2: begin
				// More bytes decoded than the length allows.
				write_length(tracker.produced + 3);
				fill_plain(40, 256);
				encode_segment();
				feed_stream();
			end
			3: begin
				// A clear followed by a code that is not a bare literal.
				emit_code(CODE_CLEAR);
				emit_code(CODE_FIRST);
				flush_bits();
				feed_stream();
			end
			4: begin
				// Code beyond the next free entry.
				emit_code(CODE_CLEAR);
				emit_code(8'h41);
				emit_code(enc_next + 1);
				flush_bits();
				feed_stream();
			end
			default: begin
				// Nonzero bits left in the cache after the end code.
				emit_code(CODE_END);
				if (pack_count > 0)
					stream_q.push_back(pack_bits[7:0] | (8'hFF << pack_count));
				pack_bits = 0;
				pack_count = 0;
				feed_stream();
				write_length(tracker.produced);
				send(KIND_FINISH, 8'($urandom), st);
			end
		endcase

		repeat (30)
			send(kind_t'($urandom_range(0, 3)), 8'($urandom), st);
		req_valid <= 1'b0;

		while (tracker.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
